// ----- src/deq_pkg.sv -----
package deq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam int REQ_W       = 3;
	localparam int PUSH_W      = 32;
	localparam int POP_W       = 32;
	localparam int STATUS_W    = 2;
	localparam int COUNT_NOW_W = 5;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_CLEAR      = 3'd4
	} req_code_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_code_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic capture;
	} ctrl_cmd_t;

	typedef struct packed {
		logic pop_ok;
	} dp_status_t;

endpackage

// ----- src/deq_if.sv -----
interface deq_req_if import deq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [PUSH_W-1:0] push_value;

	modport source (output valid, output req_type, output push_value, input ready);
	modport sink (input valid, input req_type, input push_value, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [POP_W-1:0]       pop_value;
	logic                   pop_valid;
	logic [STATUS_W-1:0]    status;
	logic [COUNT_NOW_W-1:0] count_now;

	modport source (output valid, output pop_value, output pop_valid, output status,
		output count_now, input ready);
	modport sink (input valid, input pop_value, input pop_valid, input status,
		input count_now, output ready);
endinterface

// ----- src/double_ended_queue_top.sv -----
// channel | dir | fields                                  | accepted when
// req     | in  | req_type[2:0], push_value[31:0]         | req.valid && req.ready
// rsp     | out | pop_value[31:0], pop_valid, status[1:0], | rsp.valid && rsp.ready
//         |     | count_now[4:0]                          |
// one request at a time: a push, clear or failed pop runs accept, execute, output;
// a successful pop adds a read step, which waits on the registered read of the entry store,
// and the result holds while rsp.ready stays low; req.ready is high only while no request
// is in flight and returns the cycle after the result leaves, so requests do not overlap
// arst_n clears the indices, the count, the response fields and the controller; store contents stay undefined
module double_ended_queue_top import deq_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);

	ctrl_cmd_t  cmd;
	dp_status_t st;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.st        (st)
	);

	deq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.req_type   (req.req_type),
		.push_value (req.push_value),
		.pop_value  (rsp.pop_value),
		.pop_valid  (rsp.pop_valid),
		.status     (rsp.status),
		.count_now  (rsp.count_now)
	);

endmodule

// ----- src/deq_ctrl.sv -----
module deq_ctrl import deq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output ctrl_cmd_t  cmd,
	input  dp_status_t st
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = st.pop_ok ? S_READ : S_OUT;
			end
			S_READ: begin
				cmd.capture = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_load_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_EXEC)
		else $error("accepted word not followed by execute");

	a_capture_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> $past(cmd.exec && st.pop_ok))
		else $error("read capture without a successful pop");

	a_no_pop_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && !st.pop_ok) |=> state_q == S_OUT)
		else $error("non-pop request did not go to output");

endmodule

// ----- src/deq_dp.sv -----
module deq_dp import deq_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctrl_cmd_t              cmd,
	output dp_status_t             st,
	input  logic [REQ_W-1:0]       req_type,
	input  logic [PUSH_W-1:0]      push_value,
	output logic [POP_W-1:0]       pop_value,
	output logic                   pop_valid,
	output logic [STATUS_W-1:0]    status,
	output logic [COUNT_NOW_W-1:0] count_now
);

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	logic [REQ_W-1:0]      req_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic [IDX_W-1:0]      front_q, back_q;
	logic [CNT_W-1:0]      count_q;
	logic [DATA_WIDTH-1:0] rd_q;
	logic [POP_W-1:0]      pop_value_q;
	logic                  pop_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [CNT_W-1:0]      count_now_q;

	logic [IDX_W-1:0]    front_d, back_d, wr_addr, rd_addr;
	logic [CNT_W-1:0]    count_d;
	logic                wr_en, pop_ok;
	logic [STATUS_W-1:0] status_d;
	logic                full, empty;
	logic [CNT_W:0]      ring_sum;
	logic [IDX_W-1:0]    ring_end;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		front_d  = front_q;
		back_d   = back_q;
		count_d  = count_q;
		wr_en    = 1'b0;
		wr_addr  = back_q;
		rd_addr  = front_q;
		pop_ok   = 1'b0;
		status_d = ST_OK;
		case (req_q)
			REQ_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					front_d = ring_prev(front_q);
					wr_addr = ring_prev(front_q);
					wr_en   = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			REQ_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					wr_addr = back_q;
					wr_en   = 1'b1;
					back_d  = ring_next(back_q);
					count_d = count_q + 1'b1;
				end
			end
			REQ_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_addr = front_q;
					front_d = ring_next(front_q);
					count_d = count_q - 1'b1;
					pop_ok  = 1'b1;
				end
			end
			REQ_POP_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					back_d  = ring_prev(back_q);
					rd_addr = ring_prev(back_q);
					count_d = count_q - 1'b1;
					pop_ok  = 1'b1;
				end
			end
			REQ_CLEAR: begin
				front_d = '0;
				back_d  = '0;
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign st.pop_ok = pop_ok;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			word_q <= DATA_WIDTH'(push_value);
		end
		if (cmd.exec && wr_en) begin
			mem[wr_addr] <= word_q;
		end
		if (cmd.exec) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			back_q      <= '0;
			count_q     <= '0;
			pop_value_q <= '0;
			pop_valid_q <= 1'b0;
			status_q    <= ST_OK;
			count_now_q <= '0;
		end else if (cmd.exec) begin
			front_q     <= front_d;
			back_q      <= back_d;
			count_q     <= count_d;
			pop_value_q <= '0;
			pop_valid_q <= 1'b0;
			status_q    <= status_d;
			count_now_q <= count_d;
		end else if (cmd.capture) begin
			pop_value_q <= POP_W'(rd_q);
			pop_valid_q <= 1'b1;
		end
	end

	assign pop_value = pop_value_q;
	assign pop_valid = pop_valid_q;
	assign status    = status_q;
	assign count_now = COUNT_NOW_W'(count_now_q);

	// front plus count wraps onto back
	assign ring_sum = (CNT_W + 1)'(front_q) + (CNT_W + 1)'(count_q);
	assign ring_end = (ring_sum >= (CNT_W + 1)'(DEPTH)) ?
		IDX_W'(ring_sum - (CNT_W + 1)'(DEPTH)) : IDX_W'(ring_sum);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_ring_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		ring_end == back_q)
		else $error("front, back and count disagree");

	a_valid_means_ok: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid_q |-> (status_q == ST_OK && count_now_q == count_q))
		else $error("popped word with bad status or stale count");

endmodule
